/* hdl/btcc_pkg.sv */
// ----------------------------------------------------------------------------
// btcc_pkg: shared types and constants of the button tap classifier
// Holds field widths, event and click codes, register indexes, reset
// values and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package btcc_pkg;

	// Field widths.
	localparam int OP_W    = 2;
	localparam int BTN_W   = 2;
	localparam int TIME_W  = 48;
	localparam int LEN_W   = 39;
	localparam int DL_W    = 49;
	localparam int CFG_W   = 16;
	localparam int MASK_W  = 4;
	localparam int CIDX_W  = 2;

	// Default number of button slots.
	localparam int DEF_NUM_BUTTONS = 4;

	// Microseconds per millisecond.
	localparam int US_PER_MS   = 1000;
	// US_PER_MS fits in this many bits.
	localparam int US_PER_MS_W = 10;
	// Gap in microseconds, 16-bit milliseconds times 1000.
	localparam int GAP_US_W    = CFG_W + US_PER_MS_W;

	// Span to milliseconds: multiply by ceil(2^53 / 1000) and keep the bits
	// from 53 up, which is exact for every 48-bit span. The span is taken
	// 16 bits per step, lowest chunk first, and the running sum drops 16 bits
	// after each step, which keeps the floor exact.
	localparam int CHUNK_W   = 16;
	localparam int DIV_STEPS = TIME_W / CHUNK_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);
	localparam int RECIP_W   = 44;
	localparam logic [RECIP_W-1:0] RECIP_MS = 44'd9007199254741;
	localparam int RECIP_SH  = 53;
	localparam int PROD_W    = CHUNK_W + RECIP_W;
	localparam int ACC_W     = PROD_W + 1;
	localparam int QUO_LSB   = RECIP_SH - CHUNK_W * (DIV_STEPS - 1);

	// Event kinds on the input.
	localparam logic [OP_W-1:0] OP_TICK = 2'd0;
	localparam logic [OP_W-1:0] OP_DOWN = 2'd1;
	localparam logic [OP_W-1:0] OP_UP   = 2'd2;

	// Click kinds on the output.
	localparam logic KIND_SINGLE = 1'b0;
	localparam logic KIND_DOUBLE = 1'b1;

	// Configuration register indexes.
	localparam logic [CIDX_W-1:0] CFG_MAX_TAP    = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_DOUBLE_GAP = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_MASK       = 2'd2;

	// Register reset values.
	localparam logic [CFG_W-1:0]  RST_MAX_TAP    = 16'd700;
	localparam logic [CFG_W-1:0]  RST_DOUBLE_GAP = 16'd450;
	localparam logic [MASK_W-1:0] RST_MASK       = 4'd1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic cap;        // take the input item
		logic div_step;   // one step of the millisecond reciprocal multiply
		logic upd;        // finish a press-up
		logic tick_emit;  // send the lowest firing single click
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [OP_W-1:0] op;  // kind of the item at the input
		logic btn_ok;         // input button has a slot
		logic dbl_hit;        // the press-up being finished gives a double click
		logic fire_any;       // a single click is still to be sent
		logic out_free;       // the output register can take a result
	} dp_sts_t;

endpackage

/* hdl/btcc_ctrl.sv */
// ----------------------------------------------------------------------------
// btcc_ctrl: sequencing of the button tap classifier
// Accepts items, runs the millisecond divider for press-ups, and steps
// through the firing buttons of a tick one result at a time.
// ----------------------------------------------------------------------------
module btcc_ctrl
	import btcc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;
	localparam logic [1:0] ST_TICK = 2'd3;

	logic [1:0]        state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic              accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.cap = 1'b1;
					step_d  = '0;
					if (sts.op == OP_UP && sts.btn_ok) begin
						state_d = ST_DIV;
					end else if (sts.op == OP_TICK) begin
						state_d = ST_TICK;
					end
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				step_d       = step_q + 1'b1;
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				// A double click waits for room in the output register.
				if (!sts.dbl_hit || sts.out_free) begin
					cmd.upd = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_TICK: begin
				if (!sts.fire_any) begin
					state_d = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.tick_emit = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

endmodule

/* hdl/btcc_dp.sv */
// ----------------------------------------------------------------------------
// btcc_dp: datapath of the button tap classifier
// Holds the per-button state, the configuration registers, a multi-cycle
// reciprocal multiply that divides press lengths by 1000, and the output
// register.
// ----------------------------------------------------------------------------
module btcc_dp
	import btcc_pkg::*;
#(
	parameter int NUM_BUTTONS = DEF_NUM_BUTTONS
) (
	input  logic              clk,
	input  logic              arst_n,
	// Input item fields.
	input  logic [OP_W-1:0]   in_op,
	input  logic [BTN_W-1:0]  in_btn,
	input  logic [TIME_W-1:0] in_now,
	// Configuration writes.
	input  logic              cfg_valid,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	// Controller link.
	input  dp_cmd_t           cmd,
	output dp_sts_t           sts,
	// Output register.
	input  logic              out_ready,
	output logic              out_valid,
	output logic [BTN_W-1:0]  out_btn,
	output logic              out_kind,
	output logic [LEN_W-1:0]  out_len,
	output logic              out_last
);

	localparam int IW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

	// Configuration.
	logic [CFG_W-1:0]    max_tap_q, dbl_gap_q;
	logic [MASK_W-1:0]   mask_q;
	logic [GAP_US_W-1:0] gap_us_q;

	// Per-button state.
	logic [TIME_W-1:0] start_q [NUM_BUTTONS];
	logic [LEN_W-1:0]  len_q   [NUM_BUTTONS];
	logic [DL_W-1:0]   dl_q    [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0] pend_q;
	logic [NUM_BUTTONS-1:0] fire_q, fire_d, fire_rest;

	// Captured press-up item and the millisecond conversion.
	logic [TIME_W-1:0] now_q;
	logic [BTN_W-1:0]  btn_q;
	logic              in_ok_q;
	logic [TIME_W-1:0] dq_q;
	logic [ACC_W-1:0]  acc_q;

	logic              in_ok;
	logic [IW-1:0]     in_idx, bi, sel;
	logic [TIME_W-1:0] st_rd;
	logic              st_valid;
	logic [PROD_W-1:0] prod;
	logic [ACC_W-1:0]  acc_d;
	logic [LEN_W-1:0]  quo;
	logic              is_long, in_window, dbl_hit, tap_en;
	logic [DL_W-1:0]   new_dl;
	logic              out_free;

	// Input decode.
	assign in_ok  = int'(in_btn) < NUM_BUTTONS;
	assign in_idx = IW'(in_btn);
	assign bi     = IW'(btn_q);
	assign st_rd  = in_ok ? start_q[in_idx] : '0;
	// A zero start reads as no press; time running backward gives zero length.
	assign st_valid = (st_rd != '0) && (in_now >= st_rd);

	// One step of the reciprocal multiply: the lowest chunk of the span times
	// the reciprocal, added to the running sum moved down by one chunk.
	assign prod  = PROD_W'(dq_q[CHUNK_W-1:0]) * PROD_W'(RECIP_MS);
	assign acc_d = (acc_q >> CHUNK_W) + ACC_W'(prod);
	assign quo   = acc_q[QUO_LSB +: LEN_W];

	// Press-up classification on the finished quotient.
	assign tap_en    = in_ok_q && mask_q[btn_q];
	assign is_long   = quo > LEN_W'(max_tap_q);
	assign in_window = DL_W'(now_q) <= dl_q[bi];
	assign dbl_hit   = tap_en && !is_long && pend_q[bi] && in_window;
	assign new_dl    = DL_W'(now_q) + DL_W'(gap_us_q);

	// Tick: which pending buttons have reached their deadline.
	always_comb begin
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			fire_d[i] = pend_q[i] && (DL_W'(in_now) >= dl_q[i]);
		end
	end

	// Lowest firing button and whether it is the final one.
	always_comb begin
		sel = '0;
		for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
			if (fire_q[i]) begin
				sel = IW'(i);
			end
		end
	end
	assign fire_rest = fire_q & ~(NUM_BUTTONS'(1) << sel);

	assign out_free = !out_valid || out_ready;

	assign sts.op       = in_op;
	assign sts.btn_ok   = in_ok;
	assign sts.dbl_hit  = dbl_hit;
	assign sts.fire_any = fire_q != '0;
	assign sts.out_free = out_free;

	// Configuration registers and the gap in microseconds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_tap_q <= RST_MAX_TAP;
			dbl_gap_q <= RST_DOUBLE_GAP;
			mask_q    <= RST_MASK;
			gap_us_q  <= GAP_US_W'(RST_DOUBLE_GAP) * GAP_US_W'(US_PER_MS);
		end else begin
			gap_us_q <= GAP_US_W'(dbl_gap_q) * GAP_US_W'(US_PER_MS);
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_MAX_TAP:    max_tap_q <= cfg_data;
					CFG_DOUBLE_GAP: dbl_gap_q <= cfg_data;
					CFG_MASK:       mask_q    <= cfg_data[MASK_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	// Captured item and the millisecond conversion.
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			now_q   <= in_now;
			btn_q   <= in_btn;
			in_ok_q <= in_ok;
			dq_q    <= st_valid ? (in_now - st_rd) : '0;
			acc_q   <= '0;
		end else if (cmd.div_step) begin
			dq_q  <= dq_q >> CHUNK_W;
			acc_q <= acc_d;
		end
	end

	// Per-button state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				start_q[i] <= '0;
				len_q[i]   <= '0;
				dl_q[i]    <= '0;
			end
			pend_q <= '0;
			fire_q <= '0;
		end else begin
			if (cmd.cap) begin
				if (in_op == OP_DOWN && in_ok) begin
					start_q[in_idx] <= in_now;
				end
				if (in_op == OP_TICK) begin
					fire_q <= fire_d;
				end
			end
			if (cmd.upd && in_ok_q) begin
				len_q[bi] <= quo;
				if (tap_en) begin
					if (is_long || dbl_hit) begin
						pend_q[bi] <= 1'b0;
					end else begin
						pend_q[bi] <= 1'b1;
						dl_q[bi]   <= new_dl;
					end
				end
			end
			if (cmd.tick_emit) begin
				fire_q[sel] <= 1'b0;
				pend_q[sel] <= 1'b0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.upd && dbl_hit) begin
			out_valid <= 1'b1;
		end else if (cmd.tick_emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd && dbl_hit) begin
			out_btn  <= btn_q;
			out_kind <= KIND_DOUBLE;
			out_len  <= quo;
			out_last <= 1'b1;
		end else if (cmd.tick_emit) begin
			out_btn  <= BTN_W'(sel);
			out_kind <= KIND_SINGLE;
			out_len  <= len_q[sel];
			out_last <= fire_rest == '0;
		end
	end

endmodule

/* hdl/button_tap_double_click_classifier_top.sv */
// ----------------------------------------------------------------------------
// button_tap_double_click_classifier_top: single and double click detection
//
//   Channel  Direction  Handshake          Payload
//   s_*      in         s_tvalid/s_tready  tuser op; tdata button, now_us
//   m_*      out        m_tvalid/m_tready  tuser click_kind; tdata button,
//                                          press_ms; tlast last
//   cfg_*    in         cfg_valid/ready    cfg_index, cfg_data
//
// A press-down is done at capture. A press-up runs capture, 3 steps of
// a multiply by the reciprocal of 1000 that turns microseconds into
// milliseconds, 16 bits of the span per step, and the update.
// A tick captures its firing buttons and then sends their single clicks one at a time.
// Reset is asynchronous and clears all per-button state at once.
// While the output register holds an untaken item, a result that must be
// sent waits in place; no new item is accepted until the current one is done.
// ----------------------------------------------------------------------------
module button_tap_double_click_classifier_top
	import btcc_pkg::*;
#(
	parameter int NUM_BUTTONS = DEF_NUM_BUTTONS
) (
	input  logic              clk,
	input  logic              arst_n,
	// Input items.
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [55:0]       s_tdata,   // [1:0] button, [49:2] now_us, rest zero
	input  logic [OP_W-1:0]   s_tuser,   // [1:0] op
	// Result items.
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [47:0]       m_tdata,   // [1:0] which_button, [40:2] press_ms
	output logic              m_tuser,   // [0] click_kind
	output logic              m_tlast,
	// Configuration writes.
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	dp_cmd_t          cmd;
	dp_sts_t          sts;
	logic [BTN_W-1:0] out_btn;
	logic [LEN_W-1:0] out_len;

	assign cfg_ready = 1'b1;

	btcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	btcc_dp #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_op     (s_tuser),
		.in_btn    (s_tdata[BTN_W-1:0]),
		.in_now    (s_tdata[BTN_W +: TIME_W]),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_btn   (out_btn),
		.out_kind  (m_tuser),
		.out_len   (out_len),
		.out_last  (m_tlast)
	);

	assign m_tdata = {7'd0, out_len, out_btn};

	// A double click is always the only result of its item.
	a_dbl_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_DOUBLE) |-> m_tlast)
		else $error("double click without last");

	// A press-down finishes in its capture cycle.
	a_down_fast: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == OP_DOWN) |=> s_tready)
		else $error("press-down held the input");

	// A valid press-up occupies the block while its length is divided.
	a_up_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == OP_UP) && sts.btn_ok |=> !s_tready)
		else $error("press-up did not start the divider");

endmodule
